### rtl/tmaa_pkg.sv
package tmaa_pkg;

    localparam int COORD_WIDTH_DEF      = 16;
    localparam int FACE_COUNT_WIDTH_DEF = 20;

    // fixed result widths
    localparam int TOTAL_W     = 56;
    localparam int COUNT_OUT_W = 21;

    // per-lane stage enables
    typedef struct packed {
        logic mul_en;
        logic diff_en;
        logic sq_en;
    } lane_ctrl_t;

endpackage

### rtl/tmaa_if.sv
interface tmaa_face_if #(
    parameter int COORD_WIDTH = tmaa_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic                          last_face;

    modport source (
        output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_face,
        input  ready
    );
    modport sink (
        input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_face,
        output ready
    );
endinterface

interface tmaa_result_if;
    logic                            valid;
    logic                            ready;
    logic [tmaa_pkg::TOTAL_W-1:0]     doubled_area_total;
    logic [tmaa_pkg::COUNT_OUT_W-1:0] faces_counted;
    logic                            total_saturated;

    modport source (
        output valid, doubled_area_total, faces_counted, total_saturated,
        input  ready
    );
    modport sink (
        input  valid, doubled_area_total, faces_counted, total_saturated,
        output ready
    );
endinterface

### rtl/tmaa_lane.sv
// One cross-product component: k = a*b - c*d, then |k|^2.
module tmaa_lane #(
    parameter int COORD_WIDTH = tmaa_pkg::COORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  tmaa_pkg::lane_ctrl_t         ctrl,
    input  logic signed [COORD_WIDTH:0]  a,
    input  logic signed [COORD_WIDTH:0]  b,
    input  logic signed [COORD_WIDTH:0]  c,
    input  logic signed [COORD_WIDTH:0]  d,
    output logic [4*COORD_WIDTH+3:0]     sq
);
    import tmaa_pkg::*;

    localparam int PROD_W = 2*COORD_WIDTH + 2;
    localparam int DIFF_W = PROD_W + 1;
    localparam int MAG_W  = PROD_W;
    localparam int SQ_W   = 2*MAG_W;

    logic signed [PROD_W-1:0] p0_reg, p1_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic signed [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0]        diff_abs;

    assign diff     = {p0_reg[PROD_W-1], p0_reg} - {p1_reg[PROD_W-1], p1_reg};
    assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            p0_reg <= a * b;
            p1_reg <= c * d;
        end
        if (ctrl.diff_en)
        begin
            mag_reg <= diff_abs[MAG_W-1:0];
        end
        if (ctrl.sq_en)
        begin
            sq_reg <= mag_reg * mag_reg;
        end
    end

    assign sq = sq_reg;

endmodule

### rtl/tmaa_sqrt.sv
// Floor square root, one result bit per cycle (restoring, radix 2).
module tmaa_sqrt #(
    parameter int COORD_WIDTH = tmaa_pkg::COORD_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [4*COORD_WIDTH+6:0]   radicand,
    output logic                       done,
    output logic [2*COORD_WIDTH+3:0]   root
);
    import tmaa_pkg::*;

    localparam int ROOT_W = 2*COORD_WIDTH + 4;
    localparam int RAD_W  = 2*ROOT_W;
    localparam int REM_W  = ROOT_W + 1;
    localparam int TRY_W  = ROOT_W + 3;
    localparam int ITER_W = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [ITER_W-1:0] iter_reg, iter_next;
    logic              done_reg, done_next;

    logic [TRY_W-1:0]  shifted;
    logic [TRY_W-1:0]  trial;
    logic [TRY_W-1:0]  diff;
    logic              take;

    assign shifted = {rem_reg, rad_reg[RAD_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};
    assign diff    = shifted - trial;
    assign take    = (shifted >= trial);

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        iter_next = iter_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = RAD_W'(radicand);
            rem_next  = '0;
            root_next = '0;
            iter_next = ITER_W'(ROOT_W);
        end
        else if (iter_reg != '0)
        begin
            rad_next  = {rad_reg[RAD_W-3:0], 2'b00};
            rem_next  = take ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_next = {root_reg[ROOT_W-2:0], take};
            iter_next = iter_reg - 1'b1;
            done_next = (iter_reg == ITER_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iter_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            iter_reg <= iter_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

### rtl/triangle_mesh_area_accumulator_top.sv
// Triangle mesh area accumulator. Each face item carries vertices A, B, C;
// three lanes form the cross-product components of AB x AC and square them,
// a merge stage sums the squares in two adds, the first one registered, and
// a shared bit-serial unit takes the floor square root (twice the face area),
// which adds into a saturating 56-bit total alongside a face count. A face
// flagged last_face emits one result item (total, count, saturation flag)
// and clears the totals. The root unit, which yields one result bit per
// cycle, sets the pace; faces are processed one at a time, the next face
// accepted only once the block is idle again. A result waits
// in an output register and does not hold off the next face unless a second
// last face completes while the first result is still untaken.
module triangle_mesh_area_accumulator_top #(
    parameter int COORD_WIDTH      = tmaa_pkg::COORD_WIDTH_DEF,
    parameter int FACE_COUNT_WIDTH = tmaa_pkg::FACE_COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tmaa_face_if.sink   face,
    tmaa_result_if.source result
);
    import tmaa_pkg::*;

    localparam int EDGE_W    = COORD_WIDTH + 1;
    localparam int SQ_W      = 4*COORD_WIDTH + 4;
    localparam int SUM_W     = 4*COORD_WIDTH + 7;
    localparam int ROOT_W    = 2*COORD_WIDTH + 4;
    localparam int CNT_W     = FACE_COUNT_WIDTH + 1;
    localparam int CNT_EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_DIFF = 3'd2;
    localparam logic [2:0] ST_SQ   = 3'd3;
    localparam logic [2:0] ST_ADD1 = 3'd4;
    localparam logic [2:0] ST_ADD2 = 3'd5;
    localparam logic [2:0] ST_ROOT = 3'd6;
    localparam logic [2:0] ST_ACC  = 3'd7;

    logic [2:0] state_reg, state_next;

    logic signed [EDGE_W-1:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic                     last_reg;
    logic                     accept;

    lane_ctrl_t       lane_ctrl;
    logic [SQ_W-1:0]  sq_x, sq_y, sq_z;
    logic [SUM_W-1:0] sum1_reg;
    logic [SUM_W-1:0] sum_all;

    logic              root_done;
    logic [ROOT_W-1:0] root;

    logic [TOTAL_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               sat_reg, sat_next;

    logic [TOTAL_W:0]   acc_sum;
    logic [TOTAL_W-1:0] acc_upd;
    logic               sat_upd;
    logic [CNT_W-1:0]   cnt_upd;
    logic [CNT_EXT_W-1:0] cnt_ext;

    logic                   out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]     out_total_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_sat_reg;
    logic                   out_load;

    assign face.ready = (state_reg == ST_IDLE);
    assign accept     = face.valid && face.ready;

    // edge vectors AB and AC
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ux_reg   <= {face.bx[COORD_WIDTH-1], face.bx}
                      - {face.ax[COORD_WIDTH-1], face.ax};
            uy_reg   <= {face.by_coord[COORD_WIDTH-1], face.by_coord}
                      - {face.ay[COORD_WIDTH-1], face.ay};
            uz_reg   <= {face.bz[COORD_WIDTH-1], face.bz}
                      - {face.az[COORD_WIDTH-1], face.az};
            vx_reg   <= {face.cx[COORD_WIDTH-1], face.cx}
                      - {face.ax[COORD_WIDTH-1], face.ax};
            vy_reg   <= {face.cy[COORD_WIDTH-1], face.cy}
                      - {face.ay[COORD_WIDTH-1], face.ay};
            vz_reg   <= {face.cz[COORD_WIDTH-1], face.cz}
                      - {face.az[COORD_WIDTH-1], face.az};
            last_reg <= face.last_face;
        end
    end

    assign lane_ctrl.mul_en  = (state_reg == ST_MUL);
    assign lane_ctrl.diff_en = (state_reg == ST_DIFF);
    assign lane_ctrl.sq_en   = (state_reg == ST_SQ);

    tmaa_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_x (
        .clk   (clk),
        .ctrl  (lane_ctrl),
        .a     (uy_reg),
        .b     (vz_reg),
        .c     (uz_reg),
        .d     (vy_reg),
        .sq    (sq_x)
    );

    tmaa_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_y (
        .clk   (clk),
        .ctrl  (lane_ctrl),
        .a     (uz_reg),
        .b     (vx_reg),
        .c     (ux_reg),
        .d     (vz_reg),
        .sq    (sq_y)
    );

    tmaa_lane #(.COORD_WIDTH(COORD_WIDTH)) u_lane_z (
        .clk   (clk),
        .ctrl  (lane_ctrl),
        .a     (ux_reg),
        .b     (vy_reg),
        .c     (uy_reg),
        .d     (vx_reg),
        .sq    (sq_z)
    );

    // merge: two adds, the first one registered, the second feeds the root unit load
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ADD1)
        begin
            sum1_reg <= SUM_W'(sq_x) + SUM_W'(sq_y);
        end
    end

    assign sum_all = sum1_reg + SUM_W'(sq_z);

    tmaa_sqrt #(.COORD_WIDTH(COORD_WIDTH)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_ADD2),
        .radicand (sum_all),
        .done     (root_done),
        .root     (root)
    );

    // saturating accumulate
    assign acc_sum = {1'b0, acc_reg} + (TOTAL_W + 1)'(root);
    assign acc_upd = acc_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : acc_sum[TOTAL_W-1:0];
    assign sat_upd = sat_reg | acc_sum[TOTAL_W];
    assign cnt_upd = cnt_reg[CNT_W-1] ? cnt_reg : cnt_reg + 1'b1;
    assign cnt_ext = CNT_EXT_W'(cnt_upd);

    // a finished total waits only if the previous result is still held
    assign out_load = (state_reg == ST_ACC) && last_reg
                   && !(out_valid_reg && !result.ready);

    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQ;
            ST_SQ:   state_next = ST_ADD1;
            ST_ADD1: state_next = ST_ADD2;
            ST_ADD2: state_next = ST_ROOT;
            ST_ROOT:
            begin
                if (root_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                if (!last_reg)
                begin
                    acc_next   = acc_upd;
                    cnt_next   = cnt_upd;
                    sat_next   = sat_upd;
                    state_next = ST_IDLE;
                end
                else if (out_load)
                begin
                    acc_next   = '0;
                    cnt_next   = '0;
                    sat_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_total_reg <= acc_upd;
            out_count_reg <= cnt_ext[COUNT_OUT_W-1:0];
            out_sat_reg   <= sat_upd;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.doubled_area_total = out_total_reg;
    assign result.faces_counted      = out_count_reg;
    assign result.total_saturated    = out_sat_reg;

endmodule

### tb/sv/triangle_mesh_area_accumulator_top_tb.sv
`timescale 1ns / 1ps

module triangle_mesh_area_accumulator_top_tb;

    import tmaa_pkg::*;

    localparam int CW = COORD_WIDTH_DEF;
    localparam int ITEMS = 1450;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PRESSURE_AT = 25;
    localparam int PRESSURE_HOLD = 2500;

    localparam logic signed [CW-1:0] CMIN = -(2 ** (CW - 1));
    localparam logic signed [CW-1:0] CMAX = 2 ** (CW - 1) - 1;
    localparam logic signed [CW-1:0] P55 = 16'sh5555;
    localparam logic signed [CW-1:0] PAA = 16'shAAAA;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic [COUNT_OUT_W-1:0] COUNT_CAP = 1 << FACE_COUNT_WIDTH_DEF;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by_coord;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic                 last_face;
    } face_t;

    typedef struct packed {
        logic [TOTAL_W-1:0]     total;
        logic [COUNT_OUT_W-1:0] count;
        logic                   saturated;
    } area_result_t;

    typedef struct packed {
        face_t        vertices;
        logic         typed;
        area_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tmaa_face_if #(.COORD_WIDTH(CW)) face_ch ();
    tmaa_result_if result_ch ();

    triangle_mesh_area_accumulator_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .face   (face_ch),
        .result (result_ch)
    );

    // predictor state
    logic [TOTAL_W-1:0]     mesh_total;
    logic [COUNT_OUT_W-1:0] mesh_faces;
    logic                   mesh_saturated;

    area_result_t expected_totals[$];
    stim_row_t    directed_rows[$];

    int failures;
    int faces_sent;
    int meshes_sent;
    int totals_taken;
    int largest_mesh;
    int cycle_count;
    int sender_calm;
    int receiver_calm;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("triangle_mesh_area_accumulator_top_tb: FAIL");
            $finish;
        end
    end

    // floor(sqrt(|AB x AC|^2)), i.e. twice the face area
    function automatic logic [63:0] face_doubled_area(face_t v);
        longint ux, uy, uz, vx, vy, vz;
        longint k[3];
        logic [127:0] sum, m, c_sq;
        logic [63:0] r, c;
        ux = longint'($signed(v.bx)) - longint'($signed(v.ax));
        uy = longint'($signed(v.by_coord)) - longint'($signed(v.ay));
        uz = longint'($signed(v.bz)) - longint'($signed(v.az));
        vx = longint'($signed(v.cx)) - longint'($signed(v.ax));
        vy = longint'($signed(v.cy)) - longint'($signed(v.ay));
        vz = longint'($signed(v.cz)) - longint'($signed(v.az));
        k[0] = uy * vz - uz * vy;
        k[1] = uz * vx - ux * vz;
        k[2] = ux * vy - uy * vx;
        sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = (k[i] < 0) ? 128'(-k[i]) : 128'(k[i]);
            sum = sum + m * m;
        end
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            c_sq = {64'd0, c} * {64'd0, c};
            if (c_sq <= sum)
                r = c;
        end
        return r;
    endfunction

    // adds one face into the mesh; returns 1 with the mesh result on a last face
    function automatic bit accumulate_face(face_t v, output area_result_t res);
        logic [63:0] root;
        root = face_doubled_area(v);
        res = '0;
        if (root > 64'(TOTAL_MAX) - 64'(mesh_total))
        begin
            mesh_total = TOTAL_MAX;
            mesh_saturated = 1'b1;
        end
        else
        begin
            mesh_total = mesh_total + root[TOTAL_W-1:0];
        end
        if (mesh_faces < COUNT_CAP)
            mesh_faces = mesh_faces + 1'b1;
        if (!v.last_face)
            return 1'b0;
        res.total = mesh_total;
        res.count = mesh_faces;
        res.saturated = mesh_saturated;
        mesh_total = '0;
        mesh_faces = '0;
        mesh_saturated = 1'b0;
        return 1'b1;
    endfunction

    // appends one row to the directed table
    function automatic void add_row(face_t v, bit typed, area_result_t want);
        stim_row_t row;
        row = '{v, typed, want};
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // wait before the next item; occasionally a run of back-to-back items
    function automatic int idle_draw(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 7) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic signed [CW-1:0] rand_coord(int spread);
        case (spread)
            0: return CW'($urandom);
            1: return CW'($urandom_range(0, 127)) - CW'(64);
            default:
                case ($urandom_range(0, 3))
                    0: return CMIN;
                    1: return CMAX;
                    2: return '0;
                    default: return '1;
                endcase
        endcase
    endfunction

    function automatic face_t random_face(bit last);
        logic signed [CW-1:0] c[9];
        int kind;
        int spread;
        kind = $urandom_range(0, 9);
        spread = (kind <= 4) ? 0 : (kind <= 6) ? 1 : (kind == 7) ? 2 : 0;
        for (int i = 0; i < 9; i++)
            c[i] = rand_coord(spread);
        if (kind == 8)
        begin
            // coincident vertices: zero area
            case ($urandom_range(0, 2))
                0: for (int i = 0; i < 3; i++) c[3 + i] = c[i];
                1: for (int i = 0; i < 3; i++) c[6 + i] = c[i];
                default: for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
            endcase
        end
        else if (kind == 9)
        begin
            // small triangle around a random point
            for (int i = 3; i < 9; i++)
                c[i] = c[i % 3] + rand_coord(1);
        end
        return '{c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], last};
    endfunction

    // called and returns at a falling edge
    task automatic drive_face(input face_t v, input int gap, input bit typed,
                              input area_result_t want);
        area_result_t predicted;
        if (gap > 0)
        begin
            face_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        face_ch.valid     <= 1'b1;
        face_ch.ax        <= v.ax;
        face_ch.ay        <= v.ay;
        face_ch.az        <= v.az;
        face_ch.bx        <= v.bx;
        face_ch.by_coord  <= v.by_coord;
        face_ch.bz        <= v.bz;
        face_ch.cx        <= v.cx;
        face_ch.cy        <= v.cy;
        face_ch.cz        <= v.cz;
        face_ch.last_face <= v.last_face;
        do @(posedge clk); while (!face_ch.ready);
        faces_sent++;
        if (accumulate_face(v, predicted))
            expected_totals.insert(expected_totals.size(), typed ? want : predicted);
        @(negedge clk);
    endtask

    // result side
    initial
    begin
        int wait_cycles;
        area_result_t want;
        area_result_t got;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            wait_cycles = idle_draw(receiver_calm);
            // long hold-off so the block backs up and stalls its input
            if (totals_taken == PRESSURE_AT)
                wait_cycles = PRESSURE_HOLD;
            if (wait_cycles > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            result_ch.ready <= 1'b1;
            do @(posedge clk); while (!result_ch.valid);
            totals_taken++;
            got = '{result_ch.doubled_area_total, result_ch.faces_counted,
                    result_ch.total_saturated};
            if (int'(got.count) > largest_mesh)
                largest_mesh = int'(got.count);
            if (expected_totals.size() == 0)
            begin
                $error("unexpected result item: total %0d, faces %0d",
                       got.total, got.count);
                failures++;
            end
            else
            begin
                want = expected_totals.pop_front();
                if (got.total !== want.total)
                begin
                    $error("doubled_area_total: expected %0d, got %0d",
                           want.total, got.total);
                    failures++;
                end
                if (got.count !== want.count)
                begin
                    $error("faces_counted: expected %0d, got %0d",
                           want.count, got.count);
                    failures++;
                end
                if (got.saturated !== want.saturated)
                begin
                    $error("total_saturated: expected %0d, got %0d",
                           want.saturated, got.saturated);
                    failures++;
                end
            end
        end
    end

    // face side and run control
    initial
    begin
        int mesh_len;
        int pick;
        face_ch.valid     = 1'b0;
        face_ch.ax        = '0;
        face_ch.ay        = '0;
        face_ch.az        = '0;
        face_ch.bx        = '0;
        face_ch.by_coord  = '0;
        face_ch.bz        = '0;
        face_ch.cx        = '0;
        face_ch.cy        = '0;
        face_ch.cz        = '0;
        face_ch.last_face = 1'b0;
        rst_n = 1'b0;
        mesh_total = '0;
        mesh_faces = '0;
        mesh_saturated = 1'b0;

        // A; B; C; last; typed; expected
        add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
            16'sd0, 16'sd0, 16'sd0, 1'b1}, 1'b1, '{56'd0, 21'd1, 1'b0});
        add_row('{16'sd0, 16'sd0, 16'sd0, CMAX, 16'sd0, 16'sd0,
            16'sd0, CMAX, 16'sd0, 1'b1}, 1'b1, '{56'd1073676289, 21'd1, 1'b0});
        add_row('{CMIN, CMIN, 16'sd0, CMAX, CMIN, 16'sd0,
            CMIN, CMAX, 16'sd0, 1'b1}, 1'b1, '{56'd4294836225, 21'd1, 1'b0});
        add_row('{16'sd0, CMIN, CMIN, 16'sd0, CMAX, CMIN,
            16'sd0, CMIN, CMAX, 1'b1}, 1'b1, '{56'd4294836225, 21'd1, 1'b0});
        add_row('{CMIN, 16'sd0, CMIN, CMAX, 16'sd0, CMIN,
            CMIN, 16'sd0, CMAX, 1'b1}, 1'b1, '{56'd4294836225, 21'd1, 1'b0});
        // collinear
        add_row('{16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6,
            16'sd3, 16'sd6, 16'sd9, 1'b1}, 1'b1, '{56'd0, 21'd1, 1'b0});
        // root of 2 floors to 1
        add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0, 16'sd0,
            16'sd0, 16'sd1, 16'sd1, 1'b1}, 1'b1, '{56'd1, 21'd1, 1'b0});
        // clockwise winding
        add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4, 16'sd0,
            16'sd3, 16'sd0, 16'sd0, 1'b1}, 1'b1, '{56'd12, 21'd1, 1'b0});
        add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0,
            16'sd0, 16'sd4, 16'sd0, 1'b0}, 1'b0, '0);
        add_row('{16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0,
            16'sd0, 16'sd4, 16'sd0, 1'b1}, 1'b1, '{56'd24, 21'd2, 1'b0});
        add_row('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN,
            CMIN, CMAX, CMIN, 1'b0}, 1'b0, '0);
        add_row('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX,
            CMAX, CMAX, CMIN, 1'b0}, 1'b0, '0);
        add_row('{-16'sd1, -16'sd1, -16'sd1, CMAX, CMIN, -16'sd1,
            CMIN, -16'sd1, CMAX, 1'b0}, 1'b0, '0);
        add_row('{P55, PAA, P55, PAA, P55, PAA,
            P55, P55, PAA, 1'b0}, 1'b0, '0);
        add_row('{CMAX, CMIN, CMAX, CMAX, CMAX, CMIN,
            CMIN, CMAX, CMAX, 1'b1}, 1'b0, '0);
        add_row('{PAA, P55, PAA, P55, PAA, P55,
            PAA, PAA, P55, 1'b1}, 1'b0, '0);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            drive_face(directed_rows[i].vertices, idle_draw(sender_calm),
                       directed_rows[i].typed, directed_rows[i].want);
            if (directed_rows[i].vertices.last_face)
                meshes_sent++;
        end

        // random meshes: mostly short, some long
        while (faces_sent < ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 16)
                mesh_len = $urandom_range(1, 6);
            else if (pick < 19)
                mesh_len = $urandom_range(7, 40);
            else
                mesh_len = $urandom_range(41, 150);
            if (mesh_len > ITEMS - faces_sent)
                mesh_len = ITEMS - faces_sent;
            for (int i = 0; i < mesh_len; i++)
                drive_face(random_face(i == mesh_len - 1), idle_draw(sender_calm),
                           1'b0, '0);
            meshes_sent++;
        end
        face_ch.valid <= 1'b0;

        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d faces in %0d meshes, checked %0d mesh totals",
                 faces_sent, meshes_sent, totals_taken);
        $display("largest mesh %0d faces, one output hold-off of %0d cycles",
                 largest_mesh, PRESSURE_HOLD);
        if (failures == 0)
            $display("triangle_mesh_area_accumulator_top_tb: PASS");
        else
            $display("triangle_mesh_area_accumulator_top_tb: FAIL");
        $finish;
    end

endmodule
